@@ hdl/rar_pkg.sv @@
// Package: payload types and divider request/response types for the rational add/reduce unit.
`default_nettype none
package rar_pkg;
    localparam int unsigned ValW = 33;

    typedef struct packed {
        logic signed [15:0] num_a;
        logic [15:0]        den_a;
        logic signed [15:0] num_b;
        logic [15:0]        den_b;
    } t_in_item;

    typedef struct packed {
        logic signed [33:0] sum_num;
        logic [31:0]        sum_den;
        logic               bad_input;
    } t_out_item;

    // Request and response between sequencer and divider
    typedef struct packed {
        logic           start;
        logic [ValW-1:0] dividend;
        logic [ValW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic [ValW-1:0] quot;
        logic [ValW-1:0] rem;
    } t_div_rsp;
endpackage
`default_nettype wire

@@ hdl/rar_divider.sv @@
// Restoring divider, one quotient bit per cycle, shared by all steps.
`default_nettype none
module rar_divider
    import rar_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);
    localparam int unsigned CntW = $clog2(ValW + 1);

    logic            r_busy;
    logic [CntW-1:0] r_cnt;
    logic [ValW-1:0] r_q;
    logic [ValW-1:0] r_r;
    logic [ValW-1:0] r_d;
    logic            r_done;
    logic [ValW:0]   w_trial;
    logic [ValW:0]   w_shift;

    assign w_shift = {r_r, r_q[ValW-1]};
    assign w_trial = w_shift - {1'b0, r_d};

    // Shift in one dividend bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_cnt == CntW'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(ValW);
                r_q    <= i_req.dividend;
                r_r    <= '0;
                r_d    <= i_req.divisor;
            end else if (r_busy) begin
                if (!w_trial[ValW]) begin
                    r_r <= w_trial[ValW-1:0];
                    r_q <= {r_q[ValW-2:0], 1'b1};
                end else begin
                    r_r <= w_shift[ValW-1:0];
                    r_q <= {r_q[ValW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_r;
endmodule
`default_nettype wire

@@ hdl/rational_add_reduce_unit.sv @@
// Top level: sequencer that adds two fractions and reduces the sum to lowest terms.
// Every Euclidean step and every division issues one operation to the shared bit-serial
// divider and waits for it. Each fraction (input a, input b, then the sum) costs its
// Euclidean steps, two divisions and bookkeeping in S_LOAD and S_NEXT, so the time an
// item takes grows with its total Euclidean steps. An item with a zero denominator has
// its result registered in the cycle after acceptance. The block takes a new item only
// when idle with its output register empty or being taken.
`default_nettype none
module rational_add_reduce_unit
    import rar_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_item  i_data,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_item      o_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_GCD, S_GCD_W, S_DIVM, S_DIVM_W, S_DIVD, S_DIVD_W,
        S_NEXT, S_MUL1, S_MUL2, S_SUM, S_DONE
    } t_state;

    t_state          r_state;
    logic [1:0]      r_phase;   // 0: fraction a, 1: fraction b, 2: sum
    logic [ValW-1:0] r_x, r_y, r_g;
    logic [ValW-1:0] r_mag, r_den;
    logic [ValW-1:0] r_ma, r_da, r_mb, r_db;
    logic            r_na, r_nb, r_neg;
    logic [ValW-1:0] r_ta, r_tb;
    logic            r_ov;
    t_out_item       r_out;
    t_div_req        w_req;
    t_div_rsp        w_rsp;
    logic            w_accept;
    logic            w_out_load;

    rar_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    assign w_accept = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE) || (r_ov && i_stall);
    assign o_valid  = r_ov;
    assign o_data   = r_out;

    // Load the output register with an error item or a finished sum
    assign w_out_load = (r_state == S_IDLE && w_accept
                         && (i_data.den_a == '0 || i_data.den_b == '0))
                        || (r_state == S_DONE && (!r_ov || !i_stall));

    // Drive divider operands per step
    always_comb begin
        w_req.start    = 1'b0;
        w_req.dividend = r_x;
        w_req.divisor  = r_y;
        unique case (r_state)
            S_GCD:  w_req.start = (r_y != '0);
            S_DIVM: begin
                w_req.start = 1'b1;
                w_req.dividend = r_mag;
                w_req.divisor = r_g;
            end
            S_DIVD: begin
                w_req.start = 1'b1;
                w_req.dividend = r_den;
                w_req.divisor = r_g;
            end
            default: ;
        endcase
    end

    // Sequence one item through the shared divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_phase <= '0;
        end else begin
            r_ov <= w_out_load || (r_ov && i_stall);
            unique case (r_state)
                S_IDLE: if (w_accept) begin
                    r_na <= i_data.num_a[15];
                    r_nb <= i_data.num_b[15];
                    r_ma <= ValW'(i_data.num_a[15]
                                  ? 17'(~{i_data.num_a[15], i_data.num_a} + 17'd1)
                                  : {1'b0, i_data.num_a});
                    r_mb <= ValW'(i_data.num_b[15]
                                  ? 17'(~{i_data.num_b[15], i_data.num_b} + 17'd1)
                                  : {1'b0, i_data.num_b});
                    r_da <= ValW'(i_data.den_a);
                    r_db <= ValW'(i_data.den_b);
                    if (i_data.den_a == '0 || i_data.den_b == '0) begin
                        r_out.sum_num   <= '0;
                        r_out.sum_den   <= 32'd1;
                        r_out.bad_input <= 1'b1;
                    end else begin
                        r_phase <= 2'd0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    unique case (r_phase)
                        2'd0: begin r_mag <= r_ma; r_den <= r_da;
                                    r_x <= r_ma; r_y <= r_da; end
                        2'd1: begin r_mag <= r_mb; r_den <= r_db;
                                    r_x <= r_mb; r_y <= r_db; end
                        default: begin r_x <= r_mag; r_y <= r_den; end
                    endcase
                    r_state <= S_GCD;
                end
                S_GCD: begin
                    if (r_y == '0) begin
                        r_g <= r_x;
                        r_state <= (r_x == '0) ? S_NEXT : S_DIVM;
                    end else begin
                        r_state <= S_GCD_W;
                    end
                end
                S_GCD_W: if (w_rsp.done) begin
                    r_x <= r_y;
                    r_y <= w_rsp.rem;
                    r_state <= S_GCD;
                end
                S_DIVM: r_state <= S_DIVM_W;
                S_DIVM_W: if (w_rsp.done) begin
                    r_mag <= w_rsp.quot;
                    r_state <= S_DIVD;
                end
                S_DIVD: r_state <= S_DIVD_W;
                S_DIVD_W: if (w_rsp.done) begin
                    r_den <= w_rsp.quot;
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    unique case (r_phase)
                        2'd0: begin r_ma <= r_mag; r_da <= r_den;
                                    r_phase <= 2'd1; r_state <= S_LOAD; end
                        2'd1: begin r_mb <= r_mag; r_db <= r_den; r_state <= S_MUL1; end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_MUL1: begin
                    r_ta <= ValW'(r_ma[15:0] * r_db[15:0]);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_tb  <= ValW'(r_mb[15:0] * r_da[15:0]);
                    r_den <= ValW'(r_da[15:0] * r_db[15:0]);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (r_na == r_nb) begin
                        r_mag <= r_ta + r_tb; r_neg <= r_na;
                    end else if (r_ta >= r_tb) begin
                        r_mag <= r_ta - r_tb; r_neg <= r_na;
                    end else begin
                        r_mag <= r_tb - r_ta; r_neg <= r_nb;
                    end
                    r_phase <= 2'd2;
                    r_state <= S_LOAD;
                end
                S_DONE: if (!r_ov || !i_stall) begin
                    r_out.bad_input <= 1'b0;
                    if (r_mag == '0) begin
                        r_out.sum_num <= '0;
                        r_out.sum_den <= 32'd1;
                    end else begin
                        r_out.sum_num <= r_neg ? -$signed({1'b0, r_mag})
                                               : $signed({1'b0, r_mag});
                        r_out.sum_den <= r_den[31:0];
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Divider is started only in the step just before the sequencer waits on it
    a_start_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |=> (r_state == S_GCD_W || r_state == S_DIVM_W || r_state == S_DIVD_W))
        else $error("divider start outside a wait step");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("item accepted while busy");
    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.bad_input) |-> (o_data.sum_den != '0))
        else $error("zero denominator in result");
endmodule
`default_nettype wire

@@ tb/rational_add_reduce_unit_tb.sv @@
// Testbench: rational add/reduce unit checked against an in-bench fraction arithmetic predictor.
`timescale 1ns / 1ps
`default_nettype none
module rational_add_reduce_unit_tb;
    import rar_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_data;

    t_out_item sum_queue[$];
    int        n_mismatch;
    int        n_sums;
    int        n_sent;
    int        n_bad;
    int        rx_wait;
    bit        hold_off_req;
    bit        hold_active;
    bit        rx_random;
    bit        tx_random;

    rational_add_reduce_unit u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Euclidean GCD on unsigned magnitudes
    function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
        longint unsigned r;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    // Compute the reduced sum of the two fractions in one item
    function automatic t_out_item reduced_sum(t_in_item it);
        t_out_item       res;
        longint unsigned ma, mb, da, db, g, ta, tb, dn, mag;
        bit              na, nb, ng;
        res = '0;
        da = it.den_a;
        db = it.den_b;
        if (da == 0 || db == 0) begin
            res.sum_den = 32'd1;
            res.bad_input = 1'b1;
            return res;
        end
        na = it.num_a[15];
        nb = it.num_b[15];
        ma = na ? longint'(-int'(it.num_a)) : longint'(it.num_a);
        mb = nb ? longint'(-int'(it.num_b)) : longint'(it.num_b);
        g = gcd_of(ma, da);
        ma = ma / g;
        da = da / g;
        g = gcd_of(mb, db);
        mb = mb / g;
        db = db / g;
        ta = ma * db;
        tb = mb * da;
        dn = da * db;
        if (na == nb) begin
            mag = ta + tb;
            ng = na;
        end else if (ta >= tb) begin
            mag = ta - tb;
            ng = na;
        end else begin
            mag = tb - ta;
            ng = nb;
        end
        g = gcd_of(mag, dn);
        mag = mag / g;
        dn = dn / g;
        if (mag == 0) begin
            ng = 1'b0;
            dn = 1;
        end
        res.sum_num = ng ? -34'(mag) : 34'(mag);
        res.sum_den = dn[31:0];
        return res;
    endfunction

    // Offer one item after a gap (random when tx_random is set), predict it on acceptance
    task automatic send_item(t_in_item it);
        int gap;
        gap = tx_random ? $urandom_range(0, 12) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sum_queue = {sum_queue, reduced_sum(it)};
        n_sent++;
        if (it.den_a == 0 || it.den_b == 0) n_bad++;
    endtask

    function automatic t_in_item make_item(int na, int da, int nb, int db);
        t_in_item it;
        it.num_a = 16'(na);
        it.den_a = 16'(da);
        it.num_b = 16'(nb);
        it.den_b = 16'(db);
        return it;
    endfunction

    // Random field with bias toward edges and small values
    function automatic logic [15:0] pick_field(bit is_den);
        case ($urandom_range(0, 9))
            0: return is_den ? 16'hFFFF : 16'h7FFF;
            1: return is_den ? 16'd1 : 16'h8000;
            2: return 16'($urandom_range(0, 12)) - (is_den ? 16'd0 : 16'd6);
            3, 4: return 16'($urandom_range(0, 255))
                         * (is_den ? 16'd1 : 16'(2*$urandom_range(0,1)-1));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        it.num_a = pick_field(1'b0);
        it.num_b = pick_field(1'b0);
        it.den_a = pick_field(1'b1);
        it.den_b = pick_field(1'b1);
        if (it.den_a == 0 && $urandom_range(0, 3) != 0) it.den_a = 16'd1;
        if (it.den_b == 0 && $urandom_range(0, 3) != 0) it.den_b = 16'd7;
        return it;
    endfunction

    // Drop valid and wait until every predicted sum has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sum_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_item(make_item(1, 2, 1, 3));
        send_item(make_item(-1, 2, 1, 2));
        send_item(make_item(0, 5, 0, 9));
        send_item(make_item(3, 0, 1, 1));
        send_item(make_item(3, 4, 1, 0));
        send_item(make_item(0, 0, 0, 0));
        send_item(make_item(-32768, 1, -32768, 1));
        send_item(make_item(32767, 1, 32767, 1));
        send_item(make_item(-32768, 65535, 32767, 65535));
        send_item(make_item(32767, 65535, -32768, 65534));
        send_item(make_item(-32768, 65535, -32768, 65533));
        send_item(make_item(32767, 65521, 32749, 65519));
        send_item(make_item(6, 4, -9, 6));
        send_item(make_item(-7, 3, -5, 3));
        send_item(make_item(0, 65535, -1, 65535));
        send_item(make_item(-1, 1, 1, 1));
        send_item(make_item(21845, 43690, 1, 2));
        send_item(make_item(-32767, 32768, 1, 65535));
        wait_drained();
    endtask

    task automatic test_random(int count);
        repeat (count) send_item(random_item());
        wait_drained();
    endtask

    // Receiver holds off while items keep coming so the block backs up
    task automatic test_backpressure();
        hold_off_req = 1'b1;
        repeat (6) send_item(random_item());
        wait_drained();
    endtask

    // Long receiver hold-off, counted in cycles
    always @(posedge i_clk) begin
        if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_active = 1'b1;
            repeat (3000) @(posedge i_clk);
            hold_active = 1'b0;
        end
    end

    // Receiver: random stall before each item, held high during a hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_wait = 0;
        end else if (hold_active) begin
            i_stall <= 1'b1;
        end else if (rx_wait != 0) begin
            rx_wait--;
            i_stall <= (rx_wait != 0);
        end else if (o_valid && !i_stall) begin
            rx_wait = rx_random ? $urandom_range(0, 12) : 0;
            if ($urandom_range(0, 3) == 0) rx_wait = 0;
            i_stall <= (rx_wait != 0);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Compare each accepted sum with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_sums++;
            if (sum_queue.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result %h", o_data);
            end else begin
                want = sum_queue.pop_front();
                if (o_data.sum_num !== want.sum_num || o_data.sum_den !== want.sum_den
                        || o_data.bad_input !== want.bad_input) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: exp %0d/%0d bad=%b got %0d/%0d bad=%b",
                                 want.sum_num, want.sum_den, want.bad_input,
                                 o_data.sum_num, o_data.sum_den, o_data.bad_input);
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data = '0;
        n_mismatch = 0;
        n_sums = 0;
        n_sent = 0;
        n_bad = 0;
        hold_off_req = 1'b0;
        hold_active = 1'b0;
        rx_random = 1'b1;
        tx_random = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        tx_random = 1'b0;
        rx_random = 1'b0;
        test_directed();
        rx_random = 1'b1;
        tx_random = 1'b1;
        test_random(900);
        test_backpressure();
        tx_random = 1'b0;
        rx_random = 1'b0;
        test_random(300);
        rx_random = 1'b1;
        tx_random = 1'b1;
        test_random(620);
        repeat (200) @(posedge i_clk);
        $display("sent %0d fraction pairs (%0d with a zero denominator), checked %0d sums",
                 n_sent, n_bad, n_sums);
        $display("mismatches: %0d", n_mismatch);
        if (n_mismatch == 0 && sum_queue.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Timeout
    initial begin
        #500ms;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
hdl/rar_pkg.sv
hdl/rar_divider.sv
hdl/rational_add_reduce_unit.sv
tb/rational_add_reduce_unit_tb.sv
